@@ rtl/assert_macros.svh @@
// Assertion macros used by the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define QT_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define QT_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/qtnav_pkg.sv @@
// Types, widths, status codes and the level offset function of the quadtree navigator.
package qtnav_pkg;

    localparam int IDX_W    = 31;
    localparam int LEVEL_W  = 4;
    localparam int LVL_W    = 5;
    localparam int POS_W    = 30;
    localparam int PAR_W    = 29;
    localparam int CHILD_W  = 31;
    localparam int STATUS_W = 2;

    localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_ROOT   = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_DEEP   = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_BEYOND = 2'd3;

    // First global index of a level: 1 + 4 + ... + 4^(lvl-1).
    function automatic logic [63:0] level_offset(input int lvl);
        logic [63:0] off;
        off = 64'd0;
        for (int i = 0; i < lvl; i++)
        begin
            off = {off[61:0], 2'b00} + 64'd1;
        end
        return off;
    endfunction

    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic             beyond;
    } s1_t;

    typedef struct packed {
        logic [LVL_W-1:0]   lvl;
        logic [IDX_W-1:0]   pos;
        logic [CHILD_W-1:0] off_up;
        logic [PAR_W-1:0]   off_dn;
        logic               beyond;
        logic               root;
        logic               deepest;
    } s2_t;

    typedef struct packed {
        logic [LEVEL_W-1:0]  node_level;
        logic [POS_W-1:0]    level_position;
        logic [PAR_W-1:0]    parent_index;
        logic [CHILD_W-1:0]  child_zero;
        logic [CHILD_W-1:0]  child_one;
        logic [CHILD_W-1:0]  child_two;
        logic [CHILD_W-1:0]  child_three;
        logic [STATUS_W-1:0] nav_status;
    } res_t;

endpackage

@@ rtl/qtnav_compare.sv @@
// Stage one: compare the index against every level start and the end of the tree.
module qtnav_compare #(
    parameter int MAX_DEPTH = 15
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic                         valid_in,
    input  logic [qtnav_pkg::IDX_W-1:0]  idx_in,
    output logic                         valid_reg,
    output qtnav_pkg::s1_t               data_reg,
    output logic [MAX_DEPTH:1]           ge_reg
);

    qtnav_pkg::s1_t      data_next;
    logic [MAX_DEPTH:1]  ge_next;

    always_comb
    begin
        data_next.idx    = idx_in;
        data_next.beyond = {33'd0, idx_in} >= qtnav_pkg::level_offset(MAX_DEPTH + 1);
        for (int l = 1; l <= MAX_DEPTH; l++)
        begin
            ge_next[l] = {33'd0, idx_in} >= qtnav_pkg::level_offset(l);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
            ge_reg   <= ge_next;
        end
    end

endmodule

@@ rtl/qtnav_locate.sv @@
// Stage two: pick the level, its offsets and the position within the level.
module qtnav_locate #(
    parameter int MAX_DEPTH = 15
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               valid_in,
    input  qtnav_pkg::s1_t     data_in,
    input  logic [MAX_DEPTH:1] ge_in,
    output logic               valid_reg,
    output qtnav_pkg::s2_t     data_reg
);

    logic [MAX_DEPTH+1:0]            ge_ext;
    logic [MAX_DEPTH:0]              hot;
    logic [qtnav_pkg::IDX_W-1:0]     off_sel;
    qtnav_pkg::s2_t                  data_next;

    always_comb
    begin
        // Level zero always starts at or below the index; nothing lies past the last level.
        ge_ext = {1'b0, ge_in, 1'b1};

        // Level boundary as a one-hot: the last start at or below the index.
        for (int l = 0; l <= MAX_DEPTH; l++)
        begin
            hot[l] = ge_ext[l] & !ge_ext[l + 1];
        end

        off_sel          = '0;
        data_next.lvl    = '0;
        data_next.off_up = '0;
        data_next.off_dn = '0;
        for (int l = 0; l <= MAX_DEPTH; l++)
        begin
            if (hot[l])
            begin
                data_next.lvl    = data_next.lvl | qtnav_pkg::LVL_W'(l);
                off_sel          = off_sel
                                 | qtnav_pkg::IDX_W'(qtnav_pkg::level_offset(l));
                data_next.off_up = data_next.off_up
                                 | qtnav_pkg::CHILD_W'(qtnav_pkg::level_offset(l + 1));
                data_next.off_dn = data_next.off_dn
                                 | qtnav_pkg::PAR_W'(qtnav_pkg::level_offset(
                                       (l == 0) ? 0 : l - 1));
            end
        end

        data_next.pos     = data_in.idx - off_sel;
        data_next.beyond  = data_in.beyond;
        data_next.root    = hot[0];
        data_next.deepest = ge_in[MAX_DEPTH];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

endmodule

@@ rtl/qtnav_link.sv @@
// Stage three: form parent and child indices and the status, into the output register.
module qtnav_link (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic           valid_in,
    input  qtnav_pkg::s2_t data_in,
    output logic           valid_reg,
    output qtnav_pkg::res_t res_reg
);

    qtnav_pkg::res_t res_next;

    always_comb
    begin
        res_next = '0;
        if (data_in.beyond)
        begin
            res_next.nav_status = qtnav_pkg::STATUS_BEYOND;
        end
        else
        begin
            res_next.node_level     = data_in.lvl[qtnav_pkg::LEVEL_W-1:0];
            res_next.level_position = data_in.pos[qtnav_pkg::POS_W-1:0];
            if (!data_in.root)
            begin
                res_next.parent_index = data_in.off_dn
                                      + data_in.pos[qtnav_pkg::IDX_W-1:2];
            end
            if (!data_in.deepest)
            begin
                // Quadrant goes into the low two bits of 4*pos: no carry chain between kids.
                res_next.child_zero  = data_in.off_up + {data_in.pos[28:0], 2'd0};
                res_next.child_one   = data_in.off_up + {data_in.pos[28:0], 2'd1};
                res_next.child_two   = data_in.off_up + {data_in.pos[28:0], 2'd2};
                res_next.child_three = data_in.off_up + {data_in.pos[28:0], 2'd3};
            end
            if (data_in.deepest)
            begin
                res_next.nav_status = qtnav_pkg::STATUS_DEEP;
            end
            else if (data_in.root)
            begin
                res_next.nav_status = qtnav_pkg::STATUS_ROOT;
            end
            else
            begin
                res_next.nav_status = qtnav_pkg::STATUS_OK;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg <= res_next;
        end
    end

endmodule

@@ rtl/quadtree_node_navigator.sv @@
// Quadtree node navigator top level: three-stage pipeline with valid/stall handshakes.
//
// Takes one global node index of a complete quadtree stored level by level (level L
// starts at (4^L-1)/3, levels 0 to MAX_DEPTH) and returns its level, its position in
// that level, its parent and its four children, plus a status: 0 ok, 1 root (parent
// reads 0), 2 deepest level (children read 0), 3 index past the last level (all other
// fields read 0). A new transaction is taken every cycle unless in_stall is high; each one
// passes one register stage at a time: level-start compares, level select and position
// subtract, then the parent and child adds into the output register. A stall on the
// output holds every occupied stage; empty stages keep filling, so in_stall rises only
// once all three stages hold data.
module quadtree_node_navigator #(
    parameter int MAX_DEPTH = 15
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [qtnav_pkg::IDX_W-1:0]     node_index,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [qtnav_pkg::LEVEL_W-1:0]   node_level,
    output logic [qtnav_pkg::POS_W-1:0]     level_position,
    output logic [qtnav_pkg::PAR_W-1:0]     parent_index,
    output logic [qtnav_pkg::CHILD_W-1:0]   child_zero,
    output logic [qtnav_pkg::CHILD_W-1:0]   child_one,
    output logic [qtnav_pkg::CHILD_W-1:0]   child_two,
    output logic [qtnav_pkg::CHILD_W-1:0]   child_three,
    output logic [qtnav_pkg::STATUS_W-1:0]  nav_status
);

    // Stage advance enables: a stage loads when it is empty or its successor moves.
    logic en1, en2, en3;
    logic v1, v2, v3;

    qtnav_pkg::s1_t     s1;
    logic [MAX_DEPTH:1] ge1;
    qtnav_pkg::s2_t     s2;
    qtnav_pkg::res_t    res;

    assign en3      = !v3 || !out_stall;
    assign en2      = !v2 || en3;
    assign en1      = !v1 || en2;
    assign in_stall = !en1;

    qtnav_compare #(
        .MAX_DEPTH (MAX_DEPTH)
    ) u_compare (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en1),
        .valid_in  (in_valid),
        .idx_in    (node_index),
        .valid_reg (v1),
        .data_reg  (s1),
        .ge_reg    (ge1)
    );

    qtnav_locate #(
        .MAX_DEPTH (MAX_DEPTH)
    ) u_locate (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en2),
        .valid_in  (v1),
        .data_in   (s1),
        .ge_in     (ge1),
        .valid_reg (v2),
        .data_reg  (s2)
    );

    qtnav_link u_link (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en3),
        .valid_in  (v2),
        .data_in   (s2),
        .valid_reg (v3),
        .res_reg   (res)
    );

    // Drive the result ports straight from the output register.
    assign out_valid      = v3;
    assign node_level     = res.node_level;
    assign level_position = res.level_position;
    assign parent_index   = res.parent_index;
    assign child_zero     = res.child_zero;
    assign child_one      = res.child_one;
    assign child_two      = res.child_two;
    assign child_three    = res.child_three;
    assign nav_status     = res.nav_status;

endmodule

@@ rtl/qtnav_checker.sv @@
// Port-level checker for the quadtree navigator and its bind to the top level.
`include "assert_macros.svh"

module qtnav_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            in_valid,
    input logic                            in_stall,
    input logic [qtnav_pkg::IDX_W-1:0]     node_index,
    input logic                            out_valid,
    input logic                            out_stall,
    input logic [qtnav_pkg::LEVEL_W-1:0]   node_level,
    input logic [qtnav_pkg::POS_W-1:0]     level_position,
    input logic [qtnav_pkg::PAR_W-1:0]     parent_index,
    input logic [qtnav_pkg::CHILD_W-1:0]   child_zero,
    input logic [qtnav_pkg::CHILD_W-1:0]   child_one,
    input logic [qtnav_pkg::CHILD_W-1:0]   child_two,
    input logic [qtnav_pkg::CHILD_W-1:0]   child_three,
    input logic [qtnav_pkg::STATUS_W-1:0]  nav_status
);

    // Result fields as one bus for the hold check.
    logic [$bits(qtnav_pkg::res_t)-1:0] res_bus;
    logic                               out_held;
    logic                               is_beyond;
    logic                               is_root;
    logic                               is_deep;
    logic                               has_kids;
    logic                               beyond_clear;
    logic                               root_clear;
    logic                               kids_clear;
    logic                               kids_run;

    assign res_bus      = {node_level, level_position, parent_index, child_zero, child_one,
                           child_two, child_three, nav_status};
    assign out_held     = out_valid && out_stall;
    assign is_beyond    = out_valid && nav_status == qtnav_pkg::STATUS_BEYOND;
    assign is_root      = out_valid && nav_status == qtnav_pkg::STATUS_ROOT;
    assign is_deep      = out_valid && nav_status == qtnav_pkg::STATUS_DEEP;
    assign has_kids     = out_valid && (nav_status == qtnav_pkg::STATUS_OK
                                     || nav_status == qtnav_pkg::STATUS_ROOT);
    assign kids_clear   = child_zero == 0 && child_one == 0 && child_two == 0
                       && child_three == 0;
    assign beyond_clear = node_level == 0 && level_position == 0 && parent_index == 0
                       && kids_clear;
    assign root_clear   = node_level == 0 && level_position == 0 && parent_index == 0;
    assign kids_run     = child_one == child_zero + 31'd1 && child_two == child_zero + 31'd2
                       && child_three == child_zero + 31'd3;

    `QT_ASSERT_NXT(a_out_hold, out_held, out_valid && $stable(res_bus), "stalled result changed")
    `QT_ASSERT_IMP(a_beyond_zero, is_beyond, beyond_clear, "out-of-tree result not cleared")
    `QT_ASSERT_IMP(a_root_fields, is_root, root_clear, "root result malformed")
    `QT_ASSERT_IMP(a_deep_kids, is_deep, kids_clear, "deepest node has children")
    `QT_ASSERT_IMP(a_kid_run, has_kids, kids_run, "children not consecutive")

endmodule

bind quadtree_node_navigator qtnav_checker u_qtnav_checker (.*);

@@ tb/tb_top.sv @@
// Self-checking testbench for the quadtree node navigator: directed table plus random lookups.
`timescale 1ns / 1ps

module tb_top;

    // Deepest level of the tree under test; the block is built with the same depth.
    localparam int TREE_DEPTH = 15;
    // First index past the last level: (4^(TREE_DEPTH+1) - 1) / 3.
    localparam logic [63:0] TREE_END = ((64'd1 << (2 * (TREE_DEPTH + 1))) - 64'd1) / 64'd3;
    localparam int RANDOM_LOOKUPS = 1428;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int LONG_HOLD_CYCLES = 64;
    localparam int SETTLE_CYCLES = 10;
    localparam int N_DIRECTED = 22;

    // Receiver back-pressure styles, picked at random by the receiver.
    typedef enum int {
        RX_STREAM,
        RX_LIGHT,
        RX_HEAVY,
        RX_BEAT
    } rx_mode_t;

    // One row of the directed table: the lookup, and a hand-typed answer where it is obvious.
    typedef struct {
        logic [qtnav_pkg::IDX_W-1:0] idx;
        bit                          typed;
        qtnav_pkg::res_t             want;
    } nav_row_t;

    logic                               clk = 1'b0;
    logic                               rst_n = 1'b0;
    logic                               in_valid = 1'b0;
    logic                               in_stall;
    logic [qtnav_pkg::IDX_W-1:0]        node_index = '0;
    logic                               out_valid;
    logic                               out_stall = 1'b0;
    logic [qtnav_pkg::LEVEL_W-1:0]      node_level;
    logic [qtnav_pkg::POS_W-1:0]        level_position;
    logic [qtnav_pkg::PAR_W-1:0]        parent_index;
    logic [qtnav_pkg::CHILD_W-1:0]      child_zero;
    logic [qtnav_pkg::CHILD_W-1:0]      child_one;
    logic [qtnav_pkg::CHILD_W-1:0]      child_two;
    logic [qtnav_pkg::CHILD_W-1:0]      child_three;
    logic [qtnav_pkg::STATUS_W-1:0]     nav_status;

    // Expected navigation results, oldest first.
    qtnav_pkg::res_t  nav_expect_q[$];
    int        fail_count = 0;
    int        lookups_sent = 0;
    int        results_seen = 0;
    int        root_seen = 0;
    int        deep_seen = 0;
    int        beyond_seen = 0;
    int        idle_cycles = 0;
    bit        hold_request = 1'b0;
    int        hold_left = 0;
    int        stall_cycle = 0;
    rx_mode_t  rx_mode = RX_STREAM;
    nav_row_t  directed_rows [N_DIRECTED];

    quadtree_node_navigator #(
        .MAX_DEPTH(TREE_DEPTH)
    ) u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .node_index     (node_index),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .node_level     (node_level),
        .level_position (level_position),
        .parent_index   (parent_index),
        .child_zero     (child_zero),
        .child_one      (child_one),
        .child_two      (child_two),
        .child_three    (child_three),
        .nav_status     (nav_status)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // First global index of a depth, closed form (4^d - 1) / 3.
    function automatic logic [63:0] depth_start(input int unsigned d);
        return ((64'd1 << (2 * d)) - 64'd1) / 64'd3;
    endfunction

    // Work out the full navigation result for one global index.
    function automatic qtnav_pkg::res_t navigate_node(input logic [qtnav_pkg::IDX_W-1:0] idx);
        qtnav_pkg::res_t r;
        int unsigned    d;
        logic [63:0]    pos;
        logic [63:0]    up;
        logic [63:0]    kid_base;
        logic [63:0]    kid;
        r = '0;
        // Past the last level: only the status is set.
        if ({33'd0, idx} >= TREE_END)
        begin
            r.nav_status = qtnav_pkg::STATUS_BEYOND;
            return r;
        end
        // Depth is the deepest level whose first index does not exceed idx.
        d = 0;
        while (d < TREE_DEPTH && depth_start(d + 1) <= {33'd0, idx})
            d++;
        pos = {33'd0, idx} - depth_start(d);
        r.node_level = d[qtnav_pkg::LEVEL_W-1:0];
        r.level_position = pos[qtnav_pkg::POS_W-1:0];
        r.nav_status = qtnav_pkg::STATUS_OK;
        if (d == 0)
            r.nav_status = qtnav_pkg::STATUS_ROOT;
        else
        begin
            up = depth_start(d - 1) + (pos >> 2);
            r.parent_index = up[qtnav_pkg::PAR_W-1:0];
        end
        // Nodes on the deepest level report no children.
        if (d >= TREE_DEPTH)
            r.nav_status = qtnav_pkg::STATUS_DEEP;
        else
        begin
            kid_base = depth_start(d + 1) + (pos << 2);
            r.child_zero = kid_base[qtnav_pkg::CHILD_W-1:0];
            kid = kid_base + 64'd1;
            r.child_one = kid[qtnav_pkg::CHILD_W-1:0];
            kid = kid_base + 64'd2;
            r.child_two = kid[qtnav_pkg::CHILD_W-1:0];
            kid = kid_base + 64'd3;
            r.child_three = kid[qtnav_pkg::CHILD_W-1:0];
        end
        return r;
    endfunction

    function automatic qtnav_pkg::res_t nav_result(input int lvl, input longint pos,
                                                   input longint par, input longint c0,
                                                   input longint c1, input longint c2,
                                                   input longint c3,
                                                   input logic [qtnav_pkg::STATUS_W-1:0] st);
        qtnav_pkg::res_t r;
        r.node_level = lvl[qtnav_pkg::LEVEL_W-1:0];
        r.level_position = pos[qtnav_pkg::POS_W-1:0];
        r.parent_index = par[qtnav_pkg::PAR_W-1:0];
        r.child_zero = c0[qtnav_pkg::CHILD_W-1:0];
        r.child_one = c1[qtnav_pkg::CHILD_W-1:0];
        r.child_two = c2[qtnav_pkg::CHILD_W-1:0];
        r.child_three = c3[qtnav_pkg::CHILD_W-1:0];
        r.nav_status = st;
        return r;
    endfunction

    // Random lookup: mostly a level picked evenly with a position in it, some past the tree,
    // some raw 31-bit values.
    function automatic logic [qtnav_pkg::IDX_W-1:0] pick_node_index();
        int unsigned    pick;
        int unsigned    d;
        logic [63:0]    span;
        logic [63:0]    pos;
        logic [63:0]    idx;
        pick = $urandom_range(0, 99);
        if (pick < 65)
        begin
            d = $urandom_range(0, TREE_DEPTH);
            span = 64'd1 << (2 * d);
            case ($urandom_range(0, 9))
                0: pos = 64'd0;
                1: pos = span - 64'd1;
                default: pos = {$urandom, $urandom} % span;
            endcase
            idx = depth_start(d) + pos;
        end
        else if (pick < 80)
            idx = {32'd0, $urandom_range(TREE_END[31:0], 32'h7FFF_FFFF)};
        else
            idx = {32'd0, $urandom};
        return idx[qtnav_pkg::IDX_W-1:0];
    endfunction

    // Offer one lookup and hold it until the block takes it; log the expected result then.
    task automatic send_lookup(input logic [qtnav_pkg::IDX_W-1:0] idx, input bit typed,
                               input qtnav_pkg::res_t want);
        in_valid <= 1'b1;
        node_index <= idx;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        nav_expect_q.push_back(typed ? want : navigate_node(idx));
        lookups_sent++;
    endtask

    // Drop valid for as many cycles as asked, with junk on the index bus.
    task automatic sender_gap(input int cycles);
        in_valid <= 1'b0;
        node_index <= qtnav_pkg::IDX_W'($urandom);
        repeat (cycles)
            @(posedge clk);
    endtask

    task automatic compare_field(input string name, input logic [63:0] want,
                                 input logic [63:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    // Result monitor: check each accepted transaction against the oldest expectation.
    always @(posedge clk)
    begin
        qtnav_pkg::res_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (nav_expect_q.size() == 0)
            begin
                $error("result with no lookup outstanding: node_level %0d nav_status %0d",
                       node_level, nav_status);
                fail_count++;
            end
            else
            begin
                want = nav_expect_q.pop_front();
                compare_field("node_level", want.node_level, node_level);
                compare_field("level_position", want.level_position, level_position);
                compare_field("parent_index", want.parent_index, parent_index);
                compare_field("child_zero", want.child_zero, child_zero);
                compare_field("child_one", want.child_one, child_one);
                compare_field("child_two", want.child_two, child_two);
                compare_field("child_three", want.child_three, child_three);
                compare_field("nav_status", want.nav_status, nav_status);
                results_seen++;
                case (want.nav_status)
                    qtnav_pkg::STATUS_ROOT: root_seen++;
                    qtnav_pkg::STATUS_DEEP: deep_seen++;
                    qtnav_pkg::STATUS_BEYOND: beyond_seen++;
                    default: ;
                endcase
            end
        end
    end

    // Receiver: stall in changing styles; on request, hold off for a long stretch.
    always @(posedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (hold_request)
            begin
                hold_left = LONG_HOLD_CYCLES;
                hold_request = 1'b0;
            end
            stall_cycle++;
            if (stall_cycle % 48 == 0)
                rx_mode = rx_mode_t'($urandom_range(0, 3));
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                case (rx_mode)
                    RX_STREAM: out_stall <= 1'b0;
                    RX_LIGHT:  out_stall <= ($urandom_range(0, 3) == 0);
                    RX_HEAVY:  out_stall <= ($urandom_range(0, 9) < 6);
                    default:   out_stall <= ((stall_cycle % 3) == 0);
                endcase
            end
        end
    end

    // Watchdog: end the run if no transaction moves on either side for too long.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: %0d idle cycles, %0d results outstanding",
                     idle_cycles, nav_expect_q.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Stimulus: reset, directed table, then random bursts with the pressure episodes.
    initial
    begin
        int burst;
        int n;
        bit hold_done;
        bit drain_done;
        directed_rows = '{
            // Root: parent reads 0, children 1..4.
            '{31'd0, 1'b1, nav_result(0, 0, 0, 1, 2, 3, 4, qtnav_pkg::STATUS_ROOT)},
            '{31'd1, 1'b1, nav_result(1, 0, 0, 5, 6, 7, 8, qtnav_pkg::STATUS_OK)},
            '{31'd4, 1'b1, nav_result(1, 3, 0, 17, 18, 19, 20, qtnav_pkg::STATUS_OK)},
            '{31'd2, 1'b0, '0},
            '{31'd3, 1'b0, '0},
            '{31'd5, 1'b0, '0},
            '{31'd20, 1'b0, '0},
            '{31'd21, 1'b0, '0},
            '{31'd84, 1'b0, '0},
            '{31'd85, 1'b0, '0},
            '{31'd341, 1'b0, '0},
            '{31'd89478484, 1'b0, '0},
            '{31'd89478485, 1'b0, '0},
            '{31'd357913940, 1'b0, '0},
            // Deepest level, first and last node: children read 0.
            '{31'd357913941, 1'b1,
              nav_result(15, 0, 89478485, 0, 0, 0, 0, qtnav_pkg::STATUS_DEEP)},
            '{31'd1431655764, 1'b1,
              nav_result(15, 1073741823, 357913940, 0, 0, 0, 0, qtnav_pkg::STATUS_DEEP)},
            // Past the tree: everything but the status reads 0.
            '{31'd1431655765, 1'b1, nav_result(0, 0, 0, 0, 0, 0, 0, qtnav_pkg::STATUS_BEYOND)},
            '{31'h7FFF_FFFE, 1'b1, nav_result(0, 0, 0, 0, 0, 0, 0, qtnav_pkg::STATUS_BEYOND)},
            '{31'h7FFF_FFFF, 1'b1, nav_result(0, 0, 0, 0, 0, 0, 0, qtnav_pkg::STATUS_BEYOND)},
            '{31'h0AAA_AAAA, 1'b0, '0},
            '{31'h2AAA_AAAA, 1'b0, '0},
            '{31'h4000_0000, 1'b0, '0}
        };
        hold_done = 1'b0;
        drain_done = 1'b0;

        repeat (11)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed rows go back to back.
        foreach (directed_rows[i])
            send_lookup(directed_rows[i].idx, directed_rows[i].typed, directed_rows[i].want);

        n = 0;
        while (n < RANDOM_LOOKUPS)
        begin
            if (!hold_done && n >= 400)
            begin
                // Long receiver hold while lookups keep coming: the pipe fills and
                // in_stall must rise.
                hold_done = 1'b1;
                hold_request = 1'b1;
                repeat (30)
                    send_lookup(pick_node_index(), 1'b0, '0);
                n += 30;
            end
            else if (!drain_done && n >= 900)
            begin
                // Pause the sender until every outstanding result is back.
                drain_done = 1'b1;
                in_valid <= 1'b0;
                while (nav_expect_q.size() != 0)
                    @(posedge clk);
                send_lookup(pick_node_index(), 1'b0, '0);
                n += 1;
            end
            else
            begin
                burst = $urandom_range(1, 24);
                repeat (burst)
                    send_lookup(pick_node_index(), 1'b0, '0);
                n += burst;
                case ($urandom_range(0, 3))
                    0: ;
                    1: sender_gap($urandom_range(1, 3));
                    2: sender_gap($urandom_range(1, 8));
                    default: sender_gap($urandom_range(4, 20));
                endcase
            end
        end

        // Drain, then give the pipe time to show any stray result.
        in_valid <= 1'b0;
        while (nav_expect_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);

        $display("%0d lookups sent, %0d results checked", lookups_sent, results_seen);
        $display("root %0d, deepest level %0d, past the tree %0d", root_seen, deep_seen,
                 beyond_seen);
        if (fail_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+rtl
rtl/qtnav_pkg.sv
rtl/qtnav_compare.sv
rtl/qtnav_locate.sv
rtl/qtnav_link.sv
rtl/quadtree_node_navigator.sv
rtl/qtnav_checker.sv
tb/tb_top.sv
